// ===== rtl/sra_pkg.sv =====
`default_nettype none

package sra_pkg;

    // Store capacities
    localparam int STR_LIMIT  = 32;
    localparam int REPL_LIMIT = 32;

    localparam int CHAR_W  = 8;
    localparam int OP_W    = 3;
    localparam int LEN_W   = 6;
    localparam int ADDR_W  = $clog2(STR_LIMIT);
    localparam int RADDR_W = $clog2(REPL_LIMIT);

    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_PAT   = 3'd1;
    localparam logic [OP_W-1:0] OP_REPL  = 3'd2;
    localparam logic [OP_W-1:0] OP_SUBJ  = 3'd3;
    localparam logic [OP_W-1:0] OP_RUN   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [CHAR_W-1:0] char_in;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
        logic              overflow;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_COPY,
        S_REPL,
        S_DRAIN_RD,
        S_DRAIN_LD,
        S_EMPTY
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_en;     // request taken
        logic scan_init;   // i = 0, w = 0
        logic rd_check;    // k = 0, read subject[i], pattern[0]
        logic cmp_next;    // k++, read subject[i+k+1], pattern[k+1]
        logic rd_copy;     // read subject[i]
        logic wr_copy;     // buf[w] = subject byte, w++, i++
        logic skip;        // i += pattern length
        logic rd_repl;     // k = 0, read replacement[0]
        logic wr_repl;     // buf[w] = replacement byte, w++, k++
        logic drain_init;  // n = 0
        logic out_load;    // result byte to output register, n++
        logic out_empty;   // empty-result marker to output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic run_req;
        logic scan_done;
        logic can_match;
        logic byte_eq;
        logic cmp_last;
        logic repl_empty;
        logic repl_end;
        logic res_empty;
        logic out_free;
        logic drain_last;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/sra_ram.sv =====
`default_nettype none

module sra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/sra_ctrl.sv =====
`default_nettype none

module sra_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire sra_pkg::sts_t sts,
    output sra_pkg::cmd_t      cmd
);

    sra_pkg::state_t state_reg;
    sra_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sra_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sra_pkg::S_IDLE:
            begin
                if (in_valid && sts.run_req)
                begin
                    state_next = sra_pkg::S_CHECK;
                end
            end
            sra_pkg::S_CHECK:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.res_empty ? sra_pkg::S_EMPTY : sra_pkg::S_DRAIN_RD;
                end
                else
                begin
                    state_next = sts.can_match ? sra_pkg::S_CMP : sra_pkg::S_COPY;
                end
            end
            sra_pkg::S_CMP:
            begin
                if (!sts.byte_eq)
                begin
                    state_next = sra_pkg::S_COPY;
                end
                else if (sts.cmp_last)
                begin
                    state_next = sts.repl_empty ? sra_pkg::S_CHECK : sra_pkg::S_REPL;
                end
            end
            sra_pkg::S_COPY:
            begin
                state_next = sra_pkg::S_CHECK;
            end
            sra_pkg::S_REPL:
            begin
                if (sts.repl_end)
                begin
                    state_next = sra_pkg::S_CHECK;
                end
            end
            sra_pkg::S_DRAIN_RD:
            begin
                state_next = sra_pkg::S_DRAIN_LD;
            end
            sra_pkg::S_DRAIN_LD:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.drain_last ? sra_pkg::S_IDLE : sra_pkg::S_DRAIN_RD;
                end
            end
            sra_pkg::S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    state_next = sra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sra_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            sra_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_en   = in_valid;
                cmd.scan_init = in_valid && sts.run_req;
            end
            sra_pkg::S_CHECK:
            begin
                cmd.rd_check   = !sts.scan_done;
                cmd.drain_init = sts.scan_done;
            end
            sra_pkg::S_CMP:
            begin
                if (!sts.byte_eq)
                begin
                    cmd.rd_copy = 1'b1;
                end
                else if (sts.cmp_last)
                begin
                    cmd.skip    = 1'b1;
                    cmd.rd_repl = !sts.repl_empty;
                end
                else
                begin
                    cmd.cmp_next = 1'b1;
                end
            end
            sra_pkg::S_COPY:
            begin
                cmd.wr_copy = 1'b1;
            end
            sra_pkg::S_REPL:
            begin
                cmd.wr_repl = 1'b1;
            end
            sra_pkg::S_DRAIN_RD:
            begin
                cmd = '0;
            end
            sra_pkg::S_DRAIN_LD:
            begin
                cmd.out_load = sts.out_free;
            end
            sra_pkg::S_EMPTY:
            begin
                cmd.out_empty = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // a scan step never overlaps with a taken request
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_copy || cmd.wr_repl || cmd.out_load) |-> !in_ready)
        else $error("scan activity while accepting requests");

    // run request always starts with a position check
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_init |=> (state_reg == sra_pkg::S_CHECK))
        else $error("run did not enter scan");

    // drain read is always followed by the load slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sra_pkg::S_DRAIN_RD) |=> (state_reg == sra_pkg::S_DRAIN_LD))
        else $error("drain sequence broken");
`endif

endmodule

`default_nettype wire

// ===== rtl/sra_dp.sv =====
`default_nettype none

module sra_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sra_pkg::in_item_t in_data,
    output sra_pkg::out_item_t     out_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire sra_pkg::cmd_t     cmd,
    output sra_pkg::sts_t          sts
);

    localparam logic [sra_pkg::LEN_W-1:0] STR_MAX  = sra_pkg::LEN_W'(sra_pkg::STR_LIMIT);
    localparam logic [sra_pkg::LEN_W-1:0] REPL_MAX = sra_pkg::LEN_W'(sra_pkg::REPL_LIMIT);
    localparam logic [sra_pkg::LEN_W-1:0] ONE      = sra_pkg::LEN_W'(1);

    logic [sra_pkg::LEN_W-1:0]  pat_len_reg,  pat_len_next;
    logic [sra_pkg::LEN_W-1:0]  repl_len_reg, repl_len_next;
    logic [sra_pkg::LEN_W-1:0]  subj_len_reg, subj_len_next;
    logic                       ovf_reg,      ovf_next;
    logic [sra_pkg::LEN_W-1:0]  i_reg,        i_next;
    logic [sra_pkg::LEN_W-1:0]  k_reg,        k_next;
    logic [sra_pkg::LEN_W-1:0]  w_reg,        w_next;
    logic [sra_pkg::ADDR_W-1:0] n_reg,        n_next;
    logic                       out_valid_reg, out_valid_next;
    sra_pkg::out_item_t         out_data_reg,  out_data_next;

    logic                        char_nz;
    logic                        pat_we, repl_we, subj_we, buf_we;
    logic [sra_pkg::CHAR_W-1:0]  pat_rdata, repl_rdata, subj_rdata, buf_rdata, buf_wdata;
    logic [sra_pkg::ADDR_W-1:0]  pat_raddr, subj_raddr;
    logic [sra_pkg::RADDR_W-1:0] repl_raddr;
    logic [sra_pkg::LEN_W-1:0]   k_inc, ik_inc;
    logic [sra_pkg::LEN_W:0]     match_end;

    assign char_nz   = (in_data.char_in != '0);
    assign k_inc     = k_reg + ONE;
    assign ik_inc    = i_reg + k_inc;
    assign match_end = {1'b0, i_reg} + {1'b0, pat_len_reg};

    // load decode
    always_comb
    begin
        pat_we        = 1'b0;
        repl_we       = 1'b0;
        subj_we       = 1'b0;
        pat_len_next  = pat_len_reg;
        repl_len_next = repl_len_reg;
        subj_len_next = subj_len_reg;
        ovf_next      = ovf_reg;
        if (cmd.load_en)
        begin
            unique case (in_data.opcode)
                sra_pkg::OP_CLEAR:
                begin
                    pat_len_next  = '0;
                    repl_len_next = '0;
                    subj_len_next = '0;
                    ovf_next      = 1'b0;
                end
                sra_pkg::OP_PAT:
                begin
                    if (char_nz)
                    begin
                        if (pat_len_reg >= STR_MAX)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            pat_we       = 1'b1;
                            pat_len_next = pat_len_reg + ONE;
                        end
                    end
                end
                sra_pkg::OP_REPL:
                begin
                    if (char_nz)
                    begin
                        if (repl_len_reg >= REPL_MAX)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            repl_we       = 1'b1;
                            repl_len_next = repl_len_reg + ONE;
                        end
                    end
                end
                sra_pkg::OP_SUBJ:
                begin
                    if (char_nz)
                    begin
                        if (subj_len_reg >= STR_MAX)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            subj_we       = 1'b1;
                            subj_len_next = subj_len_reg + ONE;
                        end
                    end
                end
                default:
                begin
                    ovf_next = ovf_reg;
                end
            endcase
        end
    end

    // scan counters and output register
    always_comb
    begin
        i_next         = i_reg;
        k_next         = k_reg;
        w_next         = w_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (cmd.scan_init)
        begin
            i_next = '0;
            w_next = '0;
        end
        if (cmd.rd_check || cmd.rd_repl)
        begin
            k_next = '0;
        end
        if (cmd.cmp_next || cmd.wr_repl)
        begin
            k_next = k_inc;
        end
        if (cmd.wr_copy)
        begin
            i_next = i_reg + ONE;
        end
        if (cmd.skip)
        begin
            i_next = match_end[sra_pkg::LEN_W-1:0];
        end
        if (buf_we)
        begin
            w_next = w_reg + ONE;
        end
        if (cmd.drain_init)
        begin
            n_next = '0;
        end
        if (cmd.out_load)
        begin
            n_next                 = n_reg + sra_pkg::ADDR_W'(1);
            out_valid_next         = 1'b1;
            out_data_next.out_char = buf_rdata;
            out_data_next.out_last = sts.drain_last;
            out_data_next.overflow = ovf_reg;
        end
        if (cmd.out_empty)
        begin
            out_valid_next         = 1'b1;
            out_data_next.out_char = '0;
            out_data_next.out_last = 1'b1;
            out_data_next.overflow = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg   <= '0;
            repl_len_reg  <= '0;
            subj_len_reg  <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            w_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pat_len_reg   <= pat_len_next;
            repl_len_reg  <= repl_len_next;
            subj_len_reg  <= subj_len_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            w_reg         <= w_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // read addresses
    assign subj_raddr = (cmd.rd_check || cmd.rd_copy) ? i_reg[sra_pkg::ADDR_W-1:0]
                                                      : ik_inc[sra_pkg::ADDR_W-1:0];
    assign pat_raddr  = cmd.cmp_next ? k_inc[sra_pkg::ADDR_W-1:0] : '0;
    assign repl_raddr = cmd.wr_repl ? k_inc[sra_pkg::RADDR_W-1:0] : '0;

    assign buf_we    = cmd.wr_copy || cmd.wr_repl;
    assign buf_wdata = cmd.wr_copy ? subj_rdata : repl_rdata;

    sra_ram #(.WIDTH(sra_pkg::CHAR_W), .DEPTH(sra_pkg::STR_LIMIT)) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_len_reg[sra_pkg::ADDR_W-1:0]),
        .wdata (in_data.char_in),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    sra_ram #(.WIDTH(sra_pkg::CHAR_W), .DEPTH(sra_pkg::REPL_LIMIT)) u_repl_ram (
        .clk   (clk),
        .we    (repl_we),
        .waddr (repl_len_reg[sra_pkg::RADDR_W-1:0]),
        .wdata (in_data.char_in),
        .raddr (repl_raddr),
        .rdata (repl_rdata)
    );

    sra_ram #(.WIDTH(sra_pkg::CHAR_W), .DEPTH(sra_pkg::STR_LIMIT)) u_subj_ram (
        .clk   (clk),
        .we    (subj_we),
        .waddr (subj_len_reg[sra_pkg::ADDR_W-1:0]),
        .wdata (in_data.char_in),
        .raddr (subj_raddr),
        .rdata (subj_rdata)
    );

    sra_ram #(.WIDTH(sra_pkg::CHAR_W), .DEPTH(sra_pkg::STR_LIMIT)) u_buf_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (w_reg[sra_pkg::ADDR_W-1:0]),
        .wdata (buf_wdata),
        .raddr (n_reg),
        .rdata (buf_rdata)
    );

    // status
    assign sts.run_req    = (in_data.opcode == sra_pkg::OP_RUN);
    assign sts.scan_done  = (i_reg >= subj_len_reg) || (w_reg >= STR_MAX);
    assign sts.can_match  = (pat_len_reg != '0) && (match_end <= {1'b0, subj_len_reg});
    assign sts.byte_eq    = (subj_rdata == pat_rdata);
    assign sts.cmp_last   = (k_inc == pat_len_reg);
    assign sts.repl_empty = (repl_len_reg == '0);
    assign sts.repl_end   = (k_inc == repl_len_reg) || ((w_reg + ONE) == STR_MAX);
    assign sts.res_empty  = (w_reg == '0);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.drain_last = ((sra_pkg::LEN_W'(n_reg) + ONE) == w_reg);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (pat_len_reg <= STR_MAX) && (subj_len_reg <= STR_MAX))
        else $error("pattern or subject length past capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        repl_len_reg <= REPL_MAX)
        else $error("replacement length past capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        buf_we |-> (w_reg < STR_MAX))
        else $error("result buffer write past limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (w_reg != '0))
        else $error("drain of an empty result");
`endif

endmodule

`default_nettype wire

// ===== rtl/substring_replace_all.sv =====
`default_nettype none

// Channel  | Signals                          | Moves
// ---------+----------------------------------+----------------------------------
// in       | in_valid, in_ready, in_data      | opcode + char_in, one request
// out      | out_valid, out_ready, out_data   | out_char, out_last, overflow
//
// Clear and byte-load requests are accepted back to back.
// A run request scans the subject: per position a check step, then a compare step per
// pattern byte (serial compare via one subject and one pattern RAM port), and a copy or
// replace step per written byte; a read and a load step per result byte drain the
// result buffer RAM. in_ready is low from run acceptance until the last output loads.
// rst_n is asynchronous, active low; stores read as undefined until loaded.
// A stalled out channel holds the output register; the drain waits on it.

module substring_replace_all (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sra_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sra_pkg::out_item_t     out_data
);

    sra_pkg::cmd_t cmd;
    sra_pkg::sts_t sts;

    // sequencer: load/clear in idle, then check / compare / copy / replace / drain
    sra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stores, scan counters, result buffer and output register
    sra_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
